/* hw/rtl/osb_pkg.sv */
// Shared constants, register indexes and pipeline stage types of the
// ARGB source-over blend unit. Depends on nothing; every other file uses it.
`default_nettype none

package osb_pkg;

  localparam int unsigned ChanW     = 8;
  localparam int unsigned NumChan   = 3;
  localparam int unsigned PixelW    = 32;
  localparam int unsigned WeightW   = 16;
  localparam int unsigned DenW      = 16;
  localparam int unsigned NumW      = 24;
  localparam int unsigned OpacityW  = 9;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned DivSteps  = 8;
  localparam int unsigned PrepSteps = 2;
  localparam int unsigned MulSteps  = 2;
  localparam int unsigned NumStages = PrepSteps + MulSteps + DivSteps + 1;

  localparam logic [CfgIdxW-1:0]  RegLayerOpacity = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0]  RegLayerVisible = CfgIdxW'(1);
  localparam logic [OpacityW-1:0] OpacityReset    = OpacityW'(256);
  localparam logic [ChanW-1:0]    AlphaOpaque     = 8'hFF;

  typedef logic [NumChan-1:0][ChanW-1:0] chan_vec_t;

  // After opacity scaling and classification.
  typedef struct packed {
    logic              blend;
    logic [PixelW-1:0] pass_px;
    logic [ChanW-1:0]  sa;
    logic [ChanW-1:0]  da;
    chan_vec_t         sc;
    chan_vec_t         dc;
  } osb_s1_t;

  // Source and destination weights and the blend denominator.
  typedef struct packed {
    logic               blend;
    logic [PixelW-1:0]  pass_px;
    chan_vec_t          sc;
    chan_vec_t          dc;
    logic [WeightW-1:0] w_s;
    logic [WeightW-1:0] w_d;
    logic [DenW-1:0]    den;
  } osb_s2_t;

  // Per-channel weighted products and the output alpha.
  typedef struct packed {
    logic                          blend;
    logic [PixelW-1:0]             pass_px;
    logic [NumChan-1:0][NumW-1:0]  prod_s;
    logic [NumChan-1:0][NumW-1:0]  prod_d;
    logic [DenW-1:0]               den;
    logic [ChanW-1:0]              out_a;
  } osb_s3_t;

  // Divider working set: partial remainders and quotients per channel.
  typedef struct packed {
    logic                          blend;
    logic [PixelW-1:0]             pass_px;
    logic [NumChan-1:0][NumW-1:0]  rem;
    chan_vec_t                     quo;
    logic [DenW-1:0]               den;
    logic [ChanW-1:0]              out_a;
  } osb_div_t;

endpackage

`default_nettype wire

/* hw/rtl/osb_prep.sv */
// Front stages of the blend pipeline: opacity scaling, classification and weights.
// Depends on osb_pkg.
`default_nettype none

module osb_prep (
  input  wire logic                          clk_i,
  input  wire logic [osb_pkg::PrepSteps-1:0] en_i,
  input  wire logic [osb_pkg::PixelW-1:0]    src_pixel_i,
  input  wire logic [osb_pkg::PixelW-1:0]    dst_pixel_i,
  input  wire logic [osb_pkg::OpacityW-1:0]  layer_opacity_i,
  input  wire logic                          layer_visible_i,
  output osb_pkg::osb_s2_t                   s2_o
);
  import osb_pkg::*;

  osb_s1_t s1_d, s1_q;
  osb_s2_t s2_d, s2_q;

  logic [2*ChanW-1:0] a_prod;
  logic [ChanW-1:0]   sa;
  logic               pass_dst;
  logic               pass_src;
  logic [ChanW-1:0]   inv_sa;

  // Stage one: scale the layer alpha and decide whether the pixel needs a blend.
  always_comb begin
    a_prod   = (2*ChanW)'(src_pixel_i[31:24]) * (2*ChanW)'(layer_opacity_i[ChanW-1:0]);
    sa       = layer_opacity_i[OpacityW-1] ? src_pixel_i[31:24] : a_prod[2*ChanW-1:ChanW];
    pass_dst = !layer_visible_i || (layer_opacity_i == '0) || (sa == '0);
    pass_src = (sa == AlphaOpaque);

    s1_d.blend   = !pass_dst && !pass_src;
    s1_d.pass_px = pass_dst ? dst_pixel_i : {sa, src_pixel_i[23:0]};
    s1_d.sa      = sa;
    s1_d.da      = dst_pixel_i[31:24];
    for (int c = 0; c < NumChan; c++) begin
      s1_d.sc[c] = src_pixel_i[c*ChanW +: ChanW];
      s1_d.dc[c] = dst_pixel_i[c*ChanW +: ChanW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      s1_q <= s1_d;
    end
  end

  // Stage two: w_s = 255*sa, w_d = da*(255-sa), den = w_s + w_d (at most 65025).
  always_comb begin
    inv_sa       = AlphaOpaque - s1_q.sa;
    s2_d.blend   = s1_q.blend;
    s2_d.pass_px = s1_q.pass_px;
    s2_d.sc      = s1_q.sc;
    s2_d.dc      = s1_q.dc;
    s2_d.w_s     = {s1_q.sa, ChanW'(0)} - WeightW'(s1_q.sa);
    s2_d.w_d     = WeightW'(s1_q.da) * WeightW'(inv_sa);
    s2_d.den     = s2_d.w_s + s2_d.w_d;
  end

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      s2_q <= s2_d;
    end
  end

  assign s2_o = s2_q;

endmodule

`default_nettype wire

/* hw/rtl/osb_mul.sv */
// Multiply stages of the blend pipeline: weighted colour products, numerators and
// output alpha. Depends on osb_pkg.
`default_nettype none

module osb_mul (
  input  wire logic                         clk_i,
  input  wire logic [osb_pkg::MulSteps-1:0] en_i,
  input  wire osb_pkg::osb_s2_t             s2_i,
  output osb_pkg::osb_div_t                 s4_o
);
  import osb_pkg::*;

  localparam int unsigned AlphaMulW = DenW + 9;

  osb_s3_t  s3_d, s3_q;
  osb_div_t s4_d, s4_q;

  logic [DenW:0]        den_inc;
  logic [AlphaMulW-1:0] alpha_mul;

  // floor(den/255) is ((den+1)*257) >> 16, exact for den below 65535.
  always_comb begin
    den_inc   = (DenW+1)'(s2_i.den) + (DenW+1)'(1);
    alpha_mul = AlphaMulW'({den_inc, 8'h00}) + AlphaMulW'(den_inc);

    s3_d.blend   = s2_i.blend;
    s3_d.pass_px = s2_i.pass_px;
    s3_d.den     = s2_i.den;
    s3_d.out_a   = alpha_mul[23:16];
    for (int c = 0; c < NumChan; c++) begin
      s3_d.prod_s[c] = NumW'(s2_i.sc[c]) * NumW'(s2_i.w_s);
      s3_d.prod_d[c] = NumW'(s2_i.dc[c]) * NumW'(s2_i.w_d);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      s3_q <= s3_d;
    end
  end

  // The numerator never exceeds 255*den, so it fits in 24 bits.
  always_comb begin
    s4_d.blend   = s3_q.blend;
    s4_d.pass_px = s3_q.pass_px;
    s4_d.den     = s3_q.den;
    s4_d.out_a   = s3_q.out_a;
    s4_d.quo     = '0;
    for (int c = 0; c < NumChan; c++) begin
      s4_d.rem[c] = s3_q.prod_s[c] + s3_q.prod_d[c];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      s4_q <= s4_d;
    end
  end

  assign s4_o = s4_q;

endmodule

`default_nettype wire

/* hw/rtl/osb_div.sv */
// Pipelined restoring divider: one quotient bit per stage for all three colours.
// Depends on osb_pkg.
`default_nettype none

module osb_div (
  input  wire logic                         clk_i,
  input  wire logic [osb_pkg::DivSteps-1:0] en_i,
  input  wire osb_pkg::osb_div_t            d_i,
  output osb_pkg::osb_div_t                 d_o
);
  import osb_pkg::*;

  osb_div_t st_d [DivSteps];
  osb_div_t st_q [DivSteps];

  // The quotient is at most 255 because the numerator is at most 255*den, so
  // eight steps from bit seven down cover it completely.
  for (genvar k = 0; k < DivSteps; k++) begin : g_step
    localparam int unsigned Sh = DivSteps - 1 - k;

    osb_div_t        prev;
    logic [NumW-1:0] trial;

    if (k == 0) begin : g_first
      assign prev = d_i;
    end else begin : g_next
      assign prev = st_q[k-1];
    end

    assign trial = NumW'(prev.den) << Sh;

    always_comb begin
      st_d[k] = prev;
      for (int c = 0; c < NumChan; c++) begin
        if (prev.rem[c] >= trial) begin
          st_d[k].rem[c]     = prev.rem[c] - trial;
          st_d[k].quo[c][Sh] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i[k]) begin
        st_q[k] <= st_d[k];
      end
    end
  end

  assign d_o = st_q[DivSteps-1];

endmodule

`default_nettype wire

/* hw/rtl/argb_source_over_blend_unit.sv */
// Top level of the ARGB8888 source-over blend unit: stream ports, layer registers,
// stage valid bits and output register. Depends on osb_pkg, osb_prep, osb_mul, osb_div.
`default_nettype none

// Composites one non-premultiplied ARGB8888 layer pixel over one destination
// pixel per word. Each input word carries the layer pixel in its low 32 bits and
// the canvas pixel in its high 32 bits; each output word is the blended pixel.
// The unit is a thirteen-stage pipeline that takes one word every clock cycle
// unless a stalled output holds it back, and it returns the results in input
// order. The divider resolves one quotient bit per stage over eight stages;
// opacity scaling, the weights, the products and the
// output register make up the other five. Every stage has its own valid bit and
// moves forward whenever the stage after it is empty or moving, so empty slots
// close up while the output is stalled and nothing is lost or repeated. The
// layer opacity (Q8, 256 is fully opaque, values above 256 act as 256) and the
// layer visibility are written through the configuration channel, which is
// always ready; they may only be changed while no pixel is in flight. A hidden
// layer, zero opacity or a fully transparent scaled source passes the canvas
// pixel; a scaled alpha of 255 passes the source pixel.
module argb_source_over_blend_unit (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  // Input stream.
  input  wire logic                        s_tvalid_i,
  output logic                             s_tready_o,
  input  wire logic [2*osb_pkg::PixelW-1:0] s_tdata_i,  // src_pixel [31:0], dst_pixel [63:32]
  // Output stream.
  output logic                             m_tvalid_o,
  input  wire logic                        m_tready_i,
  output logic [osb_pkg::PixelW-1:0]       m_tdata_o,   // out_pixel [31:0]
  // Configuration write channel.
  input  wire logic                        cfg_valid_i,
  output logic                             cfg_ready_o,
  input  wire logic [osb_pkg::CfgIdxW-1:0] cfg_index_i,
  input  wire logic [osb_pkg::OpacityW-1:0] cfg_data_i
);
  import osb_pkg::*;

  // Stage map: prep uses stages 0-1, multiply 2-3, divider 4-11, output 12.
  localparam int unsigned MulBase = PrepSteps;
  localparam int unsigned DivBase = PrepSteps + MulSteps;
  localparam int unsigned OutStg  = NumStages - 1;

  logic [OpacityW-1:0]  opacity_d, opacity_q;
  logic                 visible_d, visible_q;
  logic [NumStages-1:0] vld_d, vld_q;
  logic [NumStages-1:0] en;
  logic [PixelW-1:0]    out_d, out_q;

  osb_s2_t  s2;
  osb_div_t s4;
  osb_div_t div_res;

  // Layer registers. The channel never back-pressures, and an index that names
  // no register is accepted and ignored.
  assign cfg_ready_o = 1'b1;

  always_comb begin
    opacity_d = opacity_q;
    visible_d = visible_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        RegLayerOpacity: opacity_d = cfg_data_i;
        RegLayerVisible: visible_d = cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      opacity_q <= OpacityReset;
      visible_q <= 1'b1;
    end else begin
      opacity_q <= opacity_d;
      visible_q <= visible_d;
    end
  end

  // A stage loads when it is empty or its content moves on; the last stage
  // moves on when the output word is taken.
  always_comb begin
    en[OutStg] = !vld_q[OutStg] || m_tready_i;
    for (int k = NumStages - 2; k >= 0; k--) begin
      en[k] = !vld_q[k] || en[k+1];
    end
  end

  always_comb begin
    vld_d[0] = en[0] ? s_tvalid_i : vld_q[0];
    for (int k = 1; k < NumStages; k++) begin
      vld_d[k] = en[k] ? vld_q[k-1] : vld_q[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  assign s_tready_o = en[0];

  osb_prep u_prep (
    .clk_i           (clk_i),
    .en_i            (en[PrepSteps-1:0]),
    .src_pixel_i     (s_tdata_i[PixelW-1:0]),
    .dst_pixel_i     (s_tdata_i[2*PixelW-1:PixelW]),
    .layer_opacity_i (opacity_q),
    .layer_visible_i (visible_q),
    .s2_o            (s2)
  );

  osb_mul u_mul (
    .clk_i (clk_i),
    .en_i  (en[MulBase +: MulSteps]),
    .s2_i  (s2),
    .s4_o  (s4)
  );

  osb_div u_div (
    .clk_i (clk_i),
    .en_i  (en[DivBase +: DivSteps]),
    .d_i   (s4),
    .d_o   (div_res)
  );

  // Output register: the quotients never exceed 255, so they need no clamp.
  assign out_d = div_res.blend ? {div_res.out_a, div_res.quo[2], div_res.quo[1],
                                  div_res.quo[0]}
                               : div_res.pass_px;

  always_ff @(posedge clk_i) begin
    if (en[OutStg]) begin
      out_q <= out_d;
    end
  end

  assign m_tvalid_o = vld_q[OutStg];
  assign m_tdata_o  = out_q;

endmodule

`default_nettype wire

/* hw/rtl/osb_checker.sv */
// Port-level checks of the ARGB source-over blend unit, bound to its top level.
// Depends on osb_pkg and argb_source_over_blend_unit.
`default_nettype none

module osb_checker (
  input wire logic                         clk_i,
  input wire logic                         rst_ni,
  input wire logic                         s_tready_o,
  input wire logic                         m_tvalid_o,
  input wire logic                         m_tready_i,
  input wire logic [osb_pkg::PixelW-1:0]   m_tdata_o
);

  // A stalled output word stays valid.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o && !m_tready_i |=> m_tvalid_o)
    else $error("output word dropped while stalled");

  // A stalled output word keeps its value.
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o && !m_tready_i |=> $stable(m_tdata_o))
    else $error("output word changed while stalled");

  // With the output register empty, the whole pipeline can advance.
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_tvalid_o |-> s_tready_o)
    else $error("input stalled although the output is empty");

  // With the output being taken, the whole pipeline advances.
  a_ready_when_taken: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tready_i |-> s_tready_o)
    else $error("input stalled although the output is being taken");

endmodule

bind argb_source_over_blend_unit osb_checker u_osb_checker (.*);

`default_nettype wire
